// ===== rtl/lrupr_pkg.sv =====
// lrupr_pkg: shared constants and types for the lru page replacement core
// no dependencies; used by lrupr_frame_store, lrupr_cmp_unit and the top level
package lrupr_pkg;

    // default geometry
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    // fixed port widths
    localparam int CFG_W       = 5;
    localparam int PAGE_PORT_W = 16;
    localparam int IDX_OUT_W   = 4;
    localparam int FAULT_W     = 32;

    // frames_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // flags from the shared compare unit
    typedef struct packed {
        logic match;   // valid frame holds the requested page
        logic empty;   // frame not valid
        logic gt;      // stored rank above reference rank
        logic lt;      // stored rank below reference rank
    } cmp_flags_t;

endpackage

// ===== rtl/lrupr_frame_store.sv =====
// lrupr_frame_store: frame page and rank memories plus per-frame valid bits
// depends on lrupr_pkg; one registered read port, separate page and rank write ports
module lrupr_frame_store
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int IW        = (FRAMES > 1) ? $clog2(FRAMES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IW-1:0]        rd_addr,
    output logic                 rd_valid,
    output logic [PAGE_BITS-1:0] rd_page,
    output logic [IW-1:0]        rd_rank,
    input  logic                 pg_we,
    input  logic [IW-1:0]        pg_waddr,
    input  logic [PAGE_BITS-1:0] pg_wdata,
    input  logic                 rk_we,
    input  logic [IW-1:0]        rk_waddr,
    input  logic [IW-1:0]        rk_wdata,
    input  logic                 set_valid,
    input  logic [IW-1:0]        set_idx
);

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [IW-1:0]        rank_mem [FRAMES];
    logic [FRAMES-1:0]    valid_reg;

    // page memory
    always_ff @(posedge clk)
    begin
        if (pg_we)
        begin
            page_mem[pg_waddr] <= pg_wdata;
        end
        rd_page <= page_mem[rd_addr];
    end

    // rank memory
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rank_mem[rk_waddr] <= rk_wdata;
        end
        rd_rank <= rank_mem[rd_addr];
    end

    // valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end
        else
        begin
            if (set_valid)
            begin
                valid_reg[set_idx] <= 1'b1;
            end
            rd_valid <= valid_reg[rd_addr];
        end
    end

endmodule

// ===== rtl/lrupr_cmp_unit.sv =====
// lrupr_cmp_unit: shared compare unit for page match, empty test and rank ordering
// depends on lrupr_pkg; used once per frame visit by the sequencer
module lrupr_cmp_unit
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int RW        = 4
)
(
    input  logic                 valid_bit,
    input  logic [PAGE_BITS-1:0] page_data,
    input  logic [PAGE_BITS-1:0] req_page,
    input  logic [RW-1:0]        rank_data,
    input  logic [RW-1:0]        rank_ref,
    output cmp_flags_t           flags,
    output logic [RW-1:0]        rank_inc
);

    // one equality and two magnitude compares
    always_comb
    begin
        flags.match = valid_bit && (page_data == req_page);
        flags.empty = !valid_bit;
        flags.gt    = rank_data > rank_ref;
        flags.lt    = rank_data < rank_ref;
    end

    // aged rank; never overflows since valid ranks are a permutation
    assign rank_inc = rank_data + RW'(1);

endmodule

// ===== rtl/lru_page_replacement_core.sv =====
// Fully associative LRU page replacement core. Pulse start while busy is low to transfer
// one page_number; the result appears on the result ports for exactly one cycle with done
// high and cannot be held off, so the receiver must take it then. One reference runs a
// scan of the n active frames through the single registered read port of the frame
// memories, a decision step, then a rank update sweep over all FRAMES frames through the
// same port. The user must write frames_in_use via cfg_write/cfg_data only while idle;
// the core itself does not enforce this. 0 acts as 1 and values above FRAMES act as FRAMES.
module lru_page_replacement_core
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [PAGE_PORT_W-1:0] page_number,
    input  logic                   cfg_write,
    input  logic [CFG_W-1:0]       cfg_data,
    output logic                   done,
    output logic                   hit,
    output logic [IDX_OUT_W-1:0]   frame_index,
    output logic                   evicted_valid,
    output logic [PAGE_PORT_W-1:0] evicted_page,
    output logic [FAULT_W-1:0]     fault_total
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam logic [CW-1:0] FRAMES_C = CW'(FRAMES);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      cfg_reg;
    logic [CW-1:0]         n_reg, n_next, n_clamped;
    logic [CW-1:0]         addr_reg, addr_next;
    logic                  pv_reg, pv_next;
    logic [IW-1:0]         pi_reg, pi_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic                  hit_found_reg, hit_found_next;
    logic [IW-1:0]         hit_idx_reg, hit_idx_next;
    logic [IW-1:0]         hit_rank_reg, hit_rank_next;
    logic                  empty_found_reg, empty_found_next;
    logic [IW-1:0]         empty_idx_reg, empty_idx_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic [IW-1:0]         best_rank_reg, best_rank_next;
    logic [PAGE_BITS-1:0]  best_page_reg, best_page_next;
    logic [IW-1:0]         target_reg, target_next;
    logic [IW-1:0]         rref_reg, rref_next;
    logic                  fill_reg, fill_next;
    logic                  ev_reg, ev_next;
    logic [PAGE_BITS-1:0]  ev_page_reg, ev_page_next;
    logic [FAULT_W-1:0]    fault_reg, fault_next;
    logic                  done_reg, done_next;

    // store and compare unit hookup
    logic                  rd_valid;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [IW-1:0]         rd_rank;
    logic                  pg_we, rk_we, set_valid;
    logic [IW-1:0]         rk_wdata;
    logic [IW-1:0]         rank_ref;
    logic [IW-1:0]         rank_inc;
    cmp_flags_t            flags;
    logic [31:0]           ev_page_wide;

    lrupr_frame_store #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IW        (IW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (addr_reg[IW-1:0]),
        .rd_valid  (rd_valid),
        .rd_page   (rd_page),
        .rd_rank   (rd_rank),
        .pg_we     (pg_we),
        .pg_waddr  (target_next),
        .pg_wdata  (page_reg),
        .rk_we     (rk_we),
        .rk_waddr  (pi_reg),
        .rk_wdata  (rk_wdata),
        .set_valid (set_valid),
        .set_idx   (target_next)
    );

    assign rank_ref = (state_reg == ST_SCAN) ? best_rank_reg : rref_reg;

    lrupr_cmp_unit #(
        .PAGE_BITS (PAGE_BITS),
        .RW        (IW)
    ) u_cmp (
        .valid_bit (rd_valid),
        .page_data (rd_page),
        .req_page  (page_reg),
        .rank_data (rd_rank),
        .rank_ref  (rank_ref),
        .flags     (flags),
        .rank_inc  (rank_inc)
    );

    // active frame count, clamped to 1..FRAMES
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_clamped = CW'(1);
        end
        else if (32'(cfg_reg) > FRAMES)
        begin
            n_clamped = FRAMES_C;
        end
        else
        begin
            n_clamped = CW'(cfg_reg);
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        addr_next        = addr_reg;
        pv_next          = 1'b0;
        pi_next          = pi_reg;
        page_next        = page_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_rank_next    = hit_rank_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        best_idx_next    = best_idx_reg;
        best_rank_next   = best_rank_reg;
        best_page_next   = best_page_reg;
        target_next      = target_reg;
        rref_next        = rref_reg;
        fill_next        = fill_reg;
        ev_next          = ev_reg;
        ev_page_next     = ev_page_reg;
        fault_next       = fault_reg;
        done_next        = 1'b0;
        pg_we            = 1'b0;
        set_valid        = 1'b0;
        rk_we            = 1'b0;
        rk_wdata         = rank_inc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    page_next        = PAGE_BITS'(page_number);
                    n_next           = n_clamped;
                    addr_next        = '0;
                    hit_found_next   = 1'b0;
                    empty_found_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue next read
                if (addr_reg < n_reg)
                begin
                    pv_next   = 1'b1;
                    pi_next   = addr_reg[IW-1:0];
                    addr_next = addr_reg + CW'(1);
                end
                // evaluate returning frame
                if (pv_reg)
                begin
                    if (flags.match && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = pi_reg;
                        hit_rank_next  = rd_rank;
                    end
                    if (flags.empty && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = pi_reg;
                    end
                    if ((pi_reg == '0) || flags.gt)
                    begin
                        best_idx_next  = pi_reg;
                        best_rank_next = rd_rank;
                        best_page_next = rd_page;
                    end
                end
                if (addr_reg == n_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                ev_next = 1'b0;
                if (hit_found_reg)
                begin
                    target_next = hit_idx_reg;
                    rref_next   = hit_rank_reg;
                    fill_next   = 1'b0;
                end
                else
                begin
                    if (fault_reg != '1)
                    begin
                        fault_next = fault_reg + FAULT_W'(1);
                    end
                    pg_we = 1'b1;
                    if (empty_found_reg)
                    begin
                        target_next = empty_idx_reg;
                        fill_next   = 1'b1;
                        set_valid   = 1'b1;
                    end
                    else
                    begin
                        target_next  = best_idx_reg;
                        rref_next    = best_rank_reg;
                        fill_next    = 1'b0;
                        ev_next      = 1'b1;
                        ev_page_next = best_page_reg;
                    end
                end
                addr_next  = '0;
                state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                // issue next read over every frame
                if (addr_reg < FRAMES_C)
                begin
                    pv_next   = 1'b1;
                    pi_next   = addr_reg[IW-1:0];
                    addr_next = addr_reg + CW'(1);
                end
                // write back aged, refreshed or unchanged rank
                if (pv_reg)
                begin
                    rk_we = 1'b1;
                    if (pi_reg == target_reg)
                    begin
                        rk_wdata = '0;
                    end
                    else if (rd_valid && (fill_reg || flags.lt))
                    begin
                        rk_wdata = rank_inc;
                    end
                    else
                    begin
                        rk_wdata = rd_rank;
                    end
                end
                if (addr_reg == FRAMES_C)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_reg   <= CFG_RESET;
            fault_reg <= '0;
            done_reg  <= 1'b0;
            pv_reg    <= 1'b0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fault_reg <= fault_next;
            done_reg  <= done_next;
            pv_reg    <= pv_next;
            addr_reg  <= addr_next;
            if (cfg_write)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        pi_reg          <= pi_next;
        page_reg        <= page_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        hit_rank_reg    <= hit_rank_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        best_idx_reg    <= best_idx_next;
        best_rank_reg   <= best_rank_next;
        best_page_reg   <= best_page_next;
        target_reg      <= target_next;
        rref_reg        <= rref_next;
        fill_reg        <= fill_next;
        ev_reg          <= ev_next;
        ev_page_reg     <= ev_page_next;
    end

    // result ports
    assign ev_page_wide  = ev_reg ? 32'(ev_page_reg) : 32'd0;
    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign hit           = !ev_reg && !fill_reg;
    assign frame_index   = IDX_OUT_W'(target_reg);
    assign evicted_valid = ev_reg;
    assign evicted_page  = ev_page_wide[PAGE_PORT_W-1:0];
    assign fault_total   = fault_reg;

    // checks
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE))
        else $error("done without a finished update sweep");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not raise busy");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!evicted_valid && (fault_total == $past(fault_total))))
        else $error("hit evicted a page or counted a fault");

    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fault_reg >= $past(fault_reg)))
        else $error("fault total decreased");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

endmodule
